// ===== hw/rtl/pdee_pkg.sv =====
// pdee_pkg: shared types, codes and constants of the postfix evaluator
// no dependencies; every other rtl file imports it
package pdee_pkg;

  localparam int STACK_DEPTH_DEF = 64;
  localparam int DATA_W          = 32;
  localparam int CHAR_W          = 8;
  localparam int DEPTH_FIELD_W   = 7;
  localparam int STATUS_W        = 3;

  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_IGNORED   = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_UNDERFLOW = 3'd3,
    ST_DIVZERO   = 3'd4
  } pdee_status_t;

  // how the stack changes at write-back
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_PUSH,
    KIND_POP
  } pdee_kind_t;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_DIGIT,
    RES_ALU,
    RES_DIV
  } pdee_res_src_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_EXEC,
    S_DIV,
    S_WB
  } pdee_state_t;

  typedef struct packed {
    logic          load_in;
    logic          res_load;
    pdee_res_src_t res_src;
    pdee_status_t  status;
    pdee_kind_t    kind;
    logic          div_start;
    logic          commit;
  } pdee_cmd_t;

  typedef struct packed {
    logic is_digit;
    logic is_op;
    logic is_div;
    logic full;
    logic short_stack;
    logic b_zero;
    logic div_done;
    logic out_free;
  } pdee_stat_t;

endpackage

// ===== hw/rtl/pdee_if.sv =====
// pdee_char_if / pdee_result_if: valid-ready channels of the evaluator
// depends on pdee_pkg for field widths
interface pdee_char_if;
  import pdee_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              clear_first;

  modport source (output valid, character, clear_first, input ready);
  modport sink   (input valid, character, clear_first, output ready);
endinterface

interface pdee_result_if;
  import pdee_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] top_value;
  logic [DEPTH_FIELD_W-1:0] depth;
  logic [STATUS_W-1:0]      status;

  modport source (output valid, top_value, depth, status, input ready);
  modport sink   (input valid, top_value, depth, status, output ready);
endinterface

// ===== hw/rtl/pdee_divider.sv =====
// pdee_divider: iterative signed divider, one quotient bit per cycle
// depends on pdee_pkg; quotient truncates toward zero and wraps
module pdee_divider
  import pdee_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output logic              done,
  output logic [DATA_W-1:0] quotient
);

  localparam int SW = $clog2(DATA_W);

  logic              busy;
  logic [SW-1:0]     step;
  logic [DATA_W:0]   rem;
  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] mag_b;
  logic              neg;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   diff;

  assign shifted  = {rem[DATA_W-1:0], quo[DATA_W-1]};
  assign diff     = shifted - {1'b0, mag_b};
  assign quotient = neg ? (~quo + 1'b1) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == SW'(DATA_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg   <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
      quo   <= dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
      mag_b <= divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
      rem   <= '0;
    end else if (busy) begin
      if (!diff[DATA_W]) begin
        rem <= diff;
        quo <= {quo[DATA_W-2:0], 1'b1};
      end else begin
        rem <= shifted;
        quo <= {quo[DATA_W-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== hw/rtl/pdee_datapath.sv =====
// pdee_datapath: value stack memory, top register, alu, divider, output register
// depends on pdee_pkg and pdee_divider; driven by pdee_ctrl commands
module pdee_datapath
  import pdee_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [CHAR_W-1:0]        in_character,
  input  logic                     in_clear_first,
  input  pdee_cmd_t                cmd,
  output pdee_stat_t               stat,
  input  logic                     out_ready,
  output logic                     out_valid,
  output logic [DATA_W-1:0]        out_top_value,
  output logic [DEPTH_FIELD_W-1:0] out_depth,
  output logic [STATUS_W-1:0]      out_status
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  // entries below the top; the top itself lives in a register
  logic [DATA_W-1:0] mem [STACK_DEPTH];

  logic [CHAR_W-1:0] ch_q;
  logic              clr_q;
  logic [CW-1:0]     cnt;
  logic [DATA_W-1:0] top;
  logic [DATA_W-1:0] a_q;
  logic [DATA_W-1:0] res;
  pdee_status_t      status_q;
  pdee_kind_t        kind_q;

  logic [CW-1:0]     eff_cnt;
  logic [CW-1:0]     cnt_m1;
  logic [CW-1:0]     cnt_m2;
  logic [CHAR_W-1:0] digit_val;
  logic [DATA_W-1:0] prod;
  logic [DATA_W-1:0] alu;
  logic              div_done;
  logic [DATA_W-1:0] div_q;
  logic [CW-1:0]     cnt_next;
  logic [DATA_W-1:0] top_next;

  assign eff_cnt   = clr_q ? '0 : cnt;
  assign cnt_m1    = eff_cnt - CW'(1);
  assign cnt_m2    = eff_cnt - CW'(2);
  assign digit_val = ch_q - CH_ZERO;
  assign prod      = a_q * top;

  always_comb begin
    unique case (ch_q)
      CH_PLUS:  alu = a_q + top;
      CH_MINUS: alu = a_q - top;
      CH_STAR:  alu = prod;
      default:  alu = '0;
    endcase
  end

  assign stat.is_digit    = (ch_q >= CH_ZERO) && (ch_q <= CH_NINE);
  assign stat.is_op       = (ch_q == CH_PLUS) || (ch_q == CH_MINUS) ||
                            (ch_q == CH_STAR) || (ch_q == CH_SLASH);
  assign stat.is_div      = (ch_q == CH_SLASH);
  assign stat.full        = eff_cnt >= CW'(STACK_DEPTH);
  assign stat.short_stack = eff_cnt < CW'(2);
  assign stat.b_zero      = (top == '0);
  assign stat.div_done    = div_done;
  assign stat.out_free    = !out_valid || out_ready;

  pdee_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (a_q),
    .divisor  (top),
    .done     (div_done),
    .quotient (div_q)
  );

  // second operand read, registered
  always_ff @(posedge clk) begin
    a_q <= mem[cnt_m2[AW-1:0]];
  end

  // old top spills into the memory on a push
  always_ff @(posedge clk) begin
    if (cmd.commit && kind_q == KIND_PUSH && eff_cnt != '0) begin
      mem[cnt_m1[AW-1:0]] <= top;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      ch_q  <= in_character;
      clr_q <= in_clear_first;
    end
    if (cmd.res_load) begin
      unique case (cmd.res_src)
        RES_ZERO:  res <= '0;
        RES_DIGIT: res <= {{(DATA_W - CHAR_W){1'b0}}, digit_val};
        RES_ALU:   res <= alu;
        RES_DIV:   res <= div_q;
        default:   res <= '0;
      endcase
      status_q <= cmd.status;
      kind_q   <= cmd.kind;
    end
  end

  always_comb begin
    unique case (kind_q)
      KIND_PUSH: begin
        cnt_next = eff_cnt + CW'(1);
        top_next = res;
      end
      KIND_POP: begin
        cnt_next = cnt_m1;
        top_next = res;
      end
      default: begin
        cnt_next = eff_cnt;
        top_next = top;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      cnt       <= cnt_next;
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      top           <= top_next;
      out_top_value <= (cnt_next == '0) ? '0 : top_next;
      out_depth     <= DEPTH_FIELD_W'(cnt_next);
      out_status    <= status_q;
    end
  end

endmodule

// ===== hw/rtl/pdee_ctrl.sv =====
// pdee_ctrl: sequencing state machine of the postfix evaluator
// depends on pdee_pkg; drives pdee_datapath through command and status structs
module pdee_ctrl
  import pdee_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  pdee_stat_t stat,
  output pdee_cmd_t  cmd
);

  pdee_state_t state;
  pdee_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    in_ready      = 1'b0;
    cmd.load_in   = 1'b0;
    cmd.res_load  = 1'b0;
    cmd.res_src   = RES_ZERO;
    cmd.status    = ST_OK;
    cmd.kind      = KIND_NONE;
    cmd.div_start = 1'b0;
    cmd.commit    = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (stat.is_digit) begin
          cmd.res_load = 1'b1;
          if (stat.full) begin
            cmd.status = ST_OVERFLOW;
          end else begin
            cmd.res_src = RES_DIGIT;
            cmd.kind    = KIND_PUSH;
          end
          state_next = S_WB;
        end else if (stat.is_op) begin
          if (stat.short_stack) begin
            cmd.res_load = 1'b1;
            cmd.status   = ST_UNDERFLOW;
            state_next   = S_WB;
          end else begin
            state_next = S_EXEC;
          end
        end else begin
          cmd.res_load = 1'b1;
          cmd.status   = ST_IGNORED;
          state_next   = S_WB;
        end
      end
      S_EXEC: begin
        if (stat.is_div) begin
          if (stat.b_zero) begin
            cmd.res_load = 1'b1;
            cmd.status   = ST_DIVZERO;
            cmd.kind     = KIND_POP;
            state_next   = S_WB;
          end else begin
            cmd.div_start = 1'b1;
            state_next    = S_DIV;
          end
        end else begin
          cmd.res_load = 1'b1;
          cmd.res_src  = RES_ALU;
          cmd.kind     = KIND_POP;
          state_next   = S_WB;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.res_load = 1'b1;
          cmd.res_src  = RES_DIV;
          cmd.kind     = KIND_POP;
          state_next   = S_WB;
        end
      end
      S_WB: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/postfix_digit_expression_evaluator.sv =====
// postfix_digit_expression_evaluator: top level of the postfix evaluator
// depends on pdee_pkg, pdee_if, pdee_ctrl, pdee_datapath and pdee_divider
//
// Evaluates postfix expressions one ASCII character per transaction on the
// chars channel and returns one transaction per character on the results
// channel: the top of the stack (0 when empty), the stack depth and a status
// code. Digits push their value; + - * / pop two entries and push
// second-from-top op top in wrapping 32-bit two's complement, division
// truncating toward zero. Characters are handled one at a time: a digit, an
// ignored character, an overflow or an underflow passes through decode and
// write-back; + - * and a division by zero also pass through execute, and /
// waits in the divide state while the divider produces one quotient bit per
// cycle. The next character is accepted in the cycle after the result is
// registered, even while that result still waits in the output register.
// The stack lives in a memory of STACK_DEPTH words with one write and one
// registered read port, the top entry in a separate register; its contents
// are undefined after reset and need no clearing pass, since only entries
// below the depth count are ever used.
module postfix_digit_expression_evaluator
  import pdee_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input logic           clk,
  input logic           rst,
  pdee_char_if.sink     chars,
  pdee_result_if.source results
);

  // command and status between the state machine and the datapath
  pdee_cmd_t  cmd;
  pdee_stat_t stat;

  // output register fields before they reach the channel
  logic [DATA_W-1:0] top_value;

  pdee_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (chars.valid),
    .in_ready (chars.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pdee_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .in_character   (chars.character),
    .in_clear_first (chars.clear_first),
    .cmd            (cmd),
    .stat           (stat),
    .out_ready      (results.ready),
    .out_valid      (results.valid),
    .out_top_value  (top_value),
    .out_depth      (results.depth),
    .out_status     (results.status)
  );

  // result value is carried as signed on the channel
  assign results.top_value = $signed(top_value);

endmodule

// ===== tb/postfix_digit_expression_evaluator_test.sv =====
// postfix_digit_expression_evaluator_test: self-checking bench of the postfix evaluator
// depends on pdee_pkg, pdee_if and the rtl of postfix_digit_expression_evaluator
`timescale 1ns / 1ps

module postfix_digit_expression_evaluator_test;
  import pdee_pkg::*;

  localparam int HALF_PERIOD      = 5;
  localparam int RESET_CYCLES     = 4;
  localparam int RANDOM_PER_PHASE = 633;   // three phases, about 1900 random characters
  localparam int HOLD_CYCLES      = 400;   // long receiver hold-off in the last phase
  localparam int STALL_LIMIT      = 3000;  // cycles with no transaction before giving up
  localparam int DRAIN_CYCLES     = 60;    // a division plus margin

  // one result transaction as the evaluator reports it
  typedef struct packed {
    logic signed [DATA_W-1:0] top;
    logic [DEPTH_FIELD_W-1:0] depth;
    pdee_status_t             status;
  } eval_result_t;

  // one directed row: the expectation is only used where typed is set
  typedef struct packed {
    logic [CHAR_W-1:0]        ch;
    logic                     clr;
    logic                     typed;
    logic signed [DATA_W-1:0] top;
    logic [DEPTH_FIELD_W-1:0] depth;
    pdee_status_t             status;
  } directed_row_t;

  localparam int DIRECTED_ROWS = 25;
  localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
    // nothing on the stack yet: ignored characters and a short-stack operator
    '{8'h78,         1'b0, 1'b1, 32'sd0, 7'd0, ST_IGNORED},
    '{CH_PLUS,       1'b0, 1'b1, 32'sd0, 7'd0, ST_UNDERFLOW},
    '{8'h00,         1'b0, 1'b1, 32'sd0, 7'd0, ST_IGNORED},
    '{8'hFF,         1'b0, 1'b1, 32'sd0, 7'd0, ST_IGNORED},
    // largest and smallest digit, then a division by zero
    '{CH_NINE,       1'b1, 1'b1, 32'sd9, 7'd1, ST_OK},
    '{CH_ZERO,       1'b0, 1'b1, 32'sd0, 7'd2, ST_OK},
    '{CH_SLASH,      1'b0, 1'b1, 32'sd0, 7'd1, ST_DIVZERO},
    // every operator, a negative value and truncation toward zero
    '{CH_ZERO + 8'd7, 1'b0, 1'b0, 32'sd0, 7'd0, ST_OK},
    '{CH_MINUS,      1'b0, 1'b0, 32'sd0, 7'd0, ST_OK},
    '{CH_ZERO + 8'd3, 1'b0, 1'b0, 32'sd0, 7'd0, ST_OK},
    '{CH_SLASH,      1'b0, 1'b0, 32'sd0, 7'd0, ST_OK},
    '{CH_ZERO + 8'd4, 1'b0, 1'b0, 32'sd0, 7'd0, ST_OK},
    '{CH_STAR,       1'b0, 1'b0, 32'sd0, 7'd0, ST_OK},
    '{CH_ZERO + 8'd5, 1'b0, 1'b0, 32'sd0, 7'd0, ST_OK},
    '{CH_PLUS,       1'b0, 1'b0, 32'sd0, 7'd0, ST_OK},
    '{CH_SLASH,      1'b0, 1'b0, 32'sd0, 7'd0, ST_OK},
    // clear on an operator leaves an empty stack and underflows
    '{CH_STAR,       1'b1, 1'b1, 32'sd0, 7'd0, ST_UNDERFLOW},
    // characters next to the digit range are ignored
    '{8'h3A,         1'b0, 1'b1, 32'sd0, 7'd0, ST_IGNORED},
    '{CH_ZERO + 8'd1, 1'b0, 1'b0, 32'sd0, 7'd0, ST_OK},
    // clear still happens on an ignored character
    '{8'h2E,         1'b1, 1'b1, 32'sd0, 7'd0, ST_IGNORED},
    '{8'h80,         1'b0, 1'b1, 32'sd0, 7'd0, ST_IGNORED},
    '{CH_ZERO + 8'd8, 1'b0, 1'b0, 32'sd0, 7'd0, ST_OK},
    '{CH_ZERO + 8'd2, 1'b0, 1'b0, 32'sd0, 7'd0, ST_OK},
    '{CH_SLASH,      1'b0, 1'b0, 32'sd0, 7'd0, ST_OK},
    '{CH_MINUS,      1'b0, 1'b0, 32'sd0, 7'd0, ST_OK}
  };

  logic clk;
  logic rst;

  pdee_char_if   chars_ch ();
  pdee_result_if result_ch ();

  postfix_digit_expression_evaluator DUT (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars_ch.sink),
    .results (result_ch.source)
  );

  // shadow stack of the evaluator, kept in step with accepted characters
  logic [DATA_W-1:0] shadow_stack [STACK_DEPTH_DEF];
  int                shadow_depth;

  eval_result_t pending_results [$];

  int error_count;
  int char_count;
  int result_count;
  int status_seen [5];
  int send_idle_pct;
  int recv_idle_pct;
  int hold_requests;
  int stall_cycles;

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  // expected result of one character; updates the shadow stack
  function automatic eval_result_t evaluate_char(input logic [CHAR_W-1:0] ch,
                                                 input logic clr);
    eval_result_t      res;
    pdee_status_t      st;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] r;
    logic [DATA_W-1:0] mag_a;
    logic [DATA_W-1:0] mag_b;
    logic [DATA_W-1:0] quot;
    st = ST_OK;
    r  = '0;
    if (clr) shadow_depth = 0;
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      if (shadow_depth >= STACK_DEPTH_DEF) begin
        st = ST_OVERFLOW;
      end else begin
        shadow_stack[shadow_depth] = {{(DATA_W-CHAR_W){1'b0}}, ch - CH_ZERO};
        shadow_depth++;
      end
    end else if (ch == CH_PLUS || ch == CH_MINUS || ch == CH_STAR || ch == CH_SLASH) begin
      if (shadow_depth < 2) begin
        st = ST_UNDERFLOW;
      end else begin
        b = shadow_stack[shadow_depth - 1];
        a = shadow_stack[shadow_depth - 2];
        case (ch)
          CH_PLUS:  r = a + b;
          CH_MINUS: r = a - b;
          CH_STAR:  r = a * b;
          default: begin
            if (b == '0) begin
              st = ST_DIVZERO;
            end else begin
              // unsigned magnitudes, so the most negative value wraps cleanly
              mag_a = a[DATA_W-1] ? -a : a;
              mag_b = b[DATA_W-1] ? -b : b;
              quot  = mag_a / mag_b;
              r     = (a[DATA_W-1] ^ b[DATA_W-1]) ? -quot : quot;
            end
          end
        endcase
        shadow_depth--;
        shadow_stack[shadow_depth - 1] = r;
      end
    end else begin
      st = ST_IGNORED;
    end
    res.top    = (shadow_depth == 0) ? '0 : shadow_stack[shadow_depth - 1];
    res.depth  = shadow_depth[DEPTH_FIELD_W-1:0];
    res.status = st;
    return res;
  endfunction

  function automatic logic [CHAR_W-1:0] random_operator();
    case ($urandom_range(3))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      default: return CH_SLASH;
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] random_digit();
    return CH_ZERO + 8'($urandom_range(9));
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at result %0d: %s got %0d expected %0d", result_count, what, got, want);
    error_count++;
  endtask

  // offer one character; entered and left at a falling edge
  task automatic send_char(input logic [CHAR_W-1:0] ch, input logic clr,
                           input logic typed, input eval_result_t typed_res);
    eval_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      chars_ch.valid <= 1'b0;
      @(negedge clk);
    end
    chars_ch.valid       <= 1'b1;
    chars_ch.character   <= ch;
    chars_ch.clear_first <= clr;
    @(posedge clk);
    while (!chars_ch.ready) @(posedge clk);
    predicted = evaluate_char(ch, clr);
    pending_results.push_back(typed ? typed_res : predicted);
    char_count++;
    @(negedge clk);
  endtask

  task automatic send(input logic [CHAR_W-1:0] ch, input logic clr);
    send_char(ch, clr, 1'b0, '0);
  endtask

  // well-formed expression of up to eight digits, with stray spaces
  task automatic send_expression();
    int   operands;
    int   pushed;
    int   held;
    logic clr;
    operands = $urandom_range(1, 8);
    pushed   = 0;
    held     = 0;
    clr      = ($urandom_range(3) != 0);
    while (pushed < operands || held > 1) begin
      if (pushed < operands && (held < 2 || $urandom_range(1) == 1)) begin
        send(random_digit(), (pushed == 0) ? clr : 1'b0);
        pushed++;
        held++;
      end else begin
        send(random_operator(), 1'b0);
        held--;
      end
      if ($urandom_range(9) == 0) send(8'h20, 1'b0);
    end
  endtask

  // long chain, mostly multiplies, so values wrap around 32 bits
  task automatic send_wrapping_chain();
    int links;
    links = $urandom_range(5, 40);
    send(random_digit(), 1'b1);
    repeat (links) begin
      send(random_digit(), 1'b0);
      send(($urandom_range(2) == 0) ? random_operator() : CH_STAR, 1'b0);
    end
  endtask

  // two to the 31st wraps to the most negative value, then divide by minus one
  task automatic send_min_by_minus_one();
    send(CH_ZERO + 8'd2, 1'b1);
    repeat (30) begin
      send(CH_ZERO + 8'd2, 1'b0);
      send(CH_STAR, 1'b0);
    end
    send(CH_ZERO, 1'b0);
    send(CH_ZERO + 8'd1, 1'b0);
    send(CH_MINUS, 1'b0);
    send(CH_SLASH, 1'b0);
  endtask

  // fill the stack, push past full, then reduce a little
  task automatic send_fill_to_overflow();
    send(random_digit(), 1'b1);
    repeat (STACK_DEPTH_DEF - 1) send(random_digit(), 1'b0);
    repeat ($urandom_range(1, 3)) send(random_digit(), 1'b0);
    repeat ($urandom_range(1, 4)) send(random_operator(), 1'b0);
  endtask

  // operator-heavy run that keeps hitting underflow
  task automatic send_broken_run();
    repeat ($urandom_range(2, 12)) begin
      if ($urandom_range(1) == 0) send(random_operator(), $urandom_range(7) == 0);
      else send(random_digit(), $urandom_range(7) == 0);
    end
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 10)) send(8'($urandom_range(255)), $urandom_range(7) == 0);
  endtask

  // result monitor: field by field against the oldest expectation
  always @(posedge clk) begin
    eval_result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("unexpected result: top %0d depth %0d status %0d",
                 result_ch.top_value, result_ch.depth, result_ch.status);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (result_ch.top_value !== want.top)
          report_mismatch("top_value", result_ch.top_value, want.top);
        if (result_ch.depth !== want.depth)
          report_mismatch("depth", result_ch.depth, want.depth);
        if (result_ch.status !== want.status)
          report_mismatch("status", result_ch.status, want.status);
        if (want.status <= ST_DIVZERO) status_seen[want.status]++;
      end
      result_count++;
    end
  end

  // watchdog: any transaction on either channel restarts the count
  always @(posedge clk) begin
    if (rst || (chars_ch.valid && chars_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // receiver: random back-pressure, plus a long hold-off when asked for
  initial begin
    int hold_left;
    int holds_served;
    hold_left          = 0;
    holds_served       = 0;
    result_ch.ready    = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        result_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // stimulus and end of run
  initial begin
    int           pick;
    int           phase_end;
    eval_result_t typed_res;
    rst                  = 1'b1;
    chars_ch.valid       = 1'b0;
    chars_ch.character   = '0;
    chars_ch.clear_first = 1'b0;
    error_count          = 0;
    char_count           = 0;
    result_count         = 0;
    hold_requests        = 0;
    stall_cycles         = 0;
    shadow_depth         = 0;
    send_idle_pct        = 9;
    recv_idle_pct        = 81;
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // directed table
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      typed_res.top    = DIRECTED[i].top;
      typed_res.depth  = DIRECTED[i].depth;
      typed_res.status = DIRECTED[i].status;
      send_char(DIRECTED[i].ch, DIRECTED[i].clr, DIRECTED[i].typed, typed_res);
    end

    // random phases: sender-light idling, receiver-light idling, then none
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 81 : 0;
      recv_idle_pct = (phase == 0) ? 81 : (phase == 1) ? 9 : 0;
      phase_end     = char_count + RANDOM_PER_PHASE;
      send_min_by_minus_one();
      if (phase == 2) begin
        // receiver stops for a long stretch while the stack is being filled
        hold_requests++;
        send_fill_to_overflow();
      end
      while (char_count < phase_end) begin
        pick = $urandom_range(99);
        if (pick < 55)      send_expression();
        else if (pick < 70) send_wrapping_chain();
        else if (pick < 85) send_broken_run();
        else if (pick < 95) send_noise();
        else if (pick < 98) send_fill_to_overflow();
        else                send_min_by_minus_one();
      end
    end
    chars_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d characters and %0d results under three back-pressure mixes",
             char_count, result_count);
    $display("status mix ok/ignored/overflow/underflow/divzero: %0d/%0d/%0d/%0d/%0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
